// File: hdl/isotropic_total_variation_top_defines.svh
// ----------------------------------------------------------------------------
// isotropic total variation assertion macros
// shared concurrent assertion forms for the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef ISOTROPIC_TOTAL_VARIATION_TOP_DEFINES_SVH
`define ISOTROPIC_TOTAL_VARIATION_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ITV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define ITV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/itv_pkg.sv
// ----------------------------------------------------------------------------
// itv_pkg
// sizes, codes, command types and helpers of the total variation block
// ----------------------------------------------------------------------------
package itv_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 16;
   localparam int FRAC_BITS  = 8;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_W = 11;
   localparam int SUM_W  = 46;

   // dx^2 + dy^2 of two pixel-wide magnitudes
   localparam int SQ_W       = 2 * PIXEL_BITS + 1;
   // one root digit per bit pair of the radicand, plus the fraction
   localparam int ROOT_STEPS = (SQ_W + 1) / 2 + FRAC_BITS;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int RAD_W      = 2 * ROOT_STEPS;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int TERM_W     = ROOT_W;

   localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(ROOT_STEPS - 1);

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_UP,
      S_DIFF,
      S_SQ_X,
      S_SQ_Y,
      S_ROOT,
      S_ACC_V,
      S_ACC_H,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic cap_pixel;
      logic cap_up;
      logic rd_right;
      logic cap_diff;
      logic sq_x;
      logic sq_y;
      logic root_step;
      logic acc_v;
      logic acc_h;
      logic commit;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_root;
      logic root_last;
      logic frame_end;
   } dp_status_type;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(
      input logic signed [PIXEL_BITS-1:0] a,
      input logic signed [PIXEL_BITS-1:0] b
   );
      logic signed [PIXEL_BITS:0] d;
      d = $signed({a[PIXEL_BITS-1], a}) - $signed({b[PIXEL_BITS-1], b});
      if (d[PIXEL_BITS]) begin
         d = -d;
      end
      return d[PIXEL_BITS-1:0];
   endfunction

   // 0 acts as 1, anything above the maximum acts as the maximum
   function automatic logic [SIZE_W-1:0] clamp_size(
      input logic [SIZE_W-1:0] v,
      input logic [SIZE_W-1:0] vmax
   );
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > vmax) begin
         r = vmax;
      end
      return r;
   endfunction

endpackage

// File: hdl/itv_ram.sv
// ----------------------------------------------------------------------------
// itv_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module itv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/itv_ctrl.sv
// ----------------------------------------------------------------------------
// itv_ctrl
// sequencer for one pixel: line buffer reads, squares, root digits, sums
// ----------------------------------------------------------------------------
`include "isotropic_total_variation_top_defines.svh"

module itv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  itv_pkg::dp_status_type status,
   output itv_pkg::ctrl_cmd_type  cmd
);

   itv_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == itv_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itv_pkg::S_IDLE: begin
            if (req_valid) state_in = itv_pkg::S_READ_UP;
         end
         itv_pkg::S_READ_UP: state_in = itv_pkg::S_DIFF;
         itv_pkg::S_DIFF: begin
            state_in = status.need_root ? itv_pkg::S_SQ_X : itv_pkg::S_ACC_V;
         end
         itv_pkg::S_SQ_X: state_in = itv_pkg::S_SQ_Y;
         itv_pkg::S_SQ_Y: state_in = itv_pkg::S_ROOT;
         itv_pkg::S_ROOT: begin
            if (status.root_last) state_in = itv_pkg::S_ACC_V;
         end
         itv_pkg::S_ACC_V: state_in = itv_pkg::S_ACC_H;
         itv_pkg::S_ACC_H: state_in = itv_pkg::S_COMMIT;
         itv_pkg::S_COMMIT: begin
            // a finished frame waits for the output word to be free
            if (!status.frame_end || out_free) state_in = itv_pkg::S_IDLE;
         end
         default: state_in = itv_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         itv_pkg::S_IDLE:    cmd.cap_pixel = accept;
         itv_pkg::S_READ_UP: begin
            cmd.cap_up   = 1'b1;
            cmd.rd_right = 1'b1;
         end
         itv_pkg::S_DIFF:    cmd.cap_diff  = 1'b1;
         itv_pkg::S_SQ_X:    cmd.sq_x      = 1'b1;
         itv_pkg::S_SQ_Y:    cmd.sq_y      = 1'b1;
         itv_pkg::S_ROOT:    cmd.root_step = 1'b1;
         itv_pkg::S_ACC_V:   cmd.acc_v     = 1'b1;
         itv_pkg::S_ACC_H:   cmd.acc_h     = 1'b1;
         itv_pkg::S_COMMIT: begin
            cmd.commit   = !status.frame_end || out_free;
            cmd.load_out = status.frame_end && out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itv_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != itv_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ITV_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == itv_pkg::S_READ_UP,
      "accepted word did not start the line buffer read")
   `ITV_ASSERT_SAME(a_load_free, clock, reset, cmd.load_out, !rsp_valid_ff || !rsp_stall,
      "result loaded over a word still waiting")
   `ITV_ASSERT_NEXT(a_root_runs, clock, reset,
      (state_ff == itv_pkg::S_ROOT) && !status.root_last, state_ff == itv_pkg::S_ROOT,
      "root iteration left early")

endmodule

// File: hdl/itv_dp.sv
// ----------------------------------------------------------------------------
// itv_dp
// line buffer, position counters, differences, shared square unit,
// two-bit-per-step root and saturating frame sum
// ----------------------------------------------------------------------------
`include "isotropic_total_variation_top_defines.svh"

module itv_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [itv_pkg::SIZE_W-1:0]          image_width,
   input  logic [itv_pkg::SIZE_W-1:0]          image_height,
   input  logic                                frame_clear,
   input  logic signed [itv_pkg::PIXEL_BITS-1:0] req_pixel,
   input  itv_pkg::ctrl_cmd_type               cmd,
   output itv_pkg::dp_status_type              status,
   output logic [itv_pkg::SUM_W-1:0]           rsp_total_variation,
   output logic                                rsp_saturated
);

   localparam int PB = itv_pkg::PIXEL_BITS;

   // frame position and sum
   logic [itv_pkg::COL_W-1:0] col_ff, col_in;
   logic [itv_pkg::ROW_W-1:0] row_ff, row_in;
   logic [itv_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      clip_ff, clip_in;
   logic signed [PB-1:0]      left_ff, left_in;

   // per-pixel working registers
   logic signed [PB-1:0]      pix_ff, up_ff;
   logic [PB-1:0]             dx_ff, dy_ff, hx_ff;
   logic [2*PB-1:0]           sq_ff;
   logic [itv_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [itv_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [itv_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [itv_pkg::STEP_W-1:0] step_ff, step_in;

   logic [itv_pkg::SUM_W-1:0] out_sum_ff;
   logic                      out_sat_ff;

   logic [itv_pkg::SIZE_W-1:0] w_eff, h_eff;
   logic col_last, row_last;
   logic [itv_pkg::COL_W-1:0] rd_addr;
   logic signed [PB-1:0]      rd_data;

   logic [PB-1:0]             mul_op;
   logic [2*PB-1:0]           mul_prod;
   logic [itv_pkg::SQ_W-1:0]  sq_sum;

   logic [itv_pkg::REM_W+1:0] rem_cat, trial;
   logic [itv_pkg::TERM_W-1:0] term;
   logic [itv_pkg::SUM_W:0]   sum_ext;

   assign w_eff    = itv_pkg::clamp_size(image_width, itv_pkg::WIDTH_MAX);
   assign h_eff    = itv_pkg::clamp_size(image_height, itv_pkg::HEIGHT_MAX);
   assign col_last = (itv_pkg::SIZE_W'(col_ff) + itv_pkg::SIZE_W'(1)) >= w_eff;
   assign row_last = (itv_pkg::SIZE_W'(row_ff) + itv_pkg::SIZE_W'(1)) >= h_eff;

   assign status.need_root = (row_ff != '0) && !col_last;
   assign status.root_last = (step_ff == itv_pkg::STEP_LAST);
   assign status.frame_end = col_last && row_last;

   // the word above this pixel first, then the one above its right neighbor
   assign rd_addr = cmd.rd_right ? col_ff + itv_pkg::COL_W'(1) : col_ff;

   itv_ram #(
      .WIDTH(PB),
      .DEPTH(itv_pkg::MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (cmd.commit),
      .wr_addr(col_ff),
      .wr_data(pix_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // one shared multiplier: dx^2, then dy^2 added on top
   assign mul_op   = cmd.sq_y ? dy_ff : dx_ff;
   assign mul_prod = mul_op * mul_op;
   assign sq_sum   = itv_pkg::SQ_W'(sq_ff) + itv_pkg::SQ_W'(mul_prod);

   always_comb begin
      rem_cat = {rem_ff, rad_ff[itv_pkg::RAD_W-1 -: 2]};
      trial   = (itv_pkg::REM_W + 2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      if (cmd.sq_y) begin
         // radicand scaled by 2^16 gives 8 fraction bits in the root
         rad_in  = itv_pkg::RAD_W'({sq_sum, {(2 * itv_pkg::FRAC_BITS){1'b0}}});
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
      end else if (cmd.root_step) begin
         rad_in  = rad_ff << 2;
         step_in = step_ff + itv_pkg::STEP_W'(1);
         if (rem_cat >= trial) begin
            rem_in  = itv_pkg::REM_W'(rem_cat - trial);
            root_in = {root_ff[itv_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = itv_pkg::REM_W'(rem_cat);
            root_in = {root_ff[itv_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      term = '0;
      if (cmd.acc_v && (row_ff != '0)) begin
         term = col_last ? itv_pkg::TERM_W'({dy_ff, {itv_pkg::FRAC_BITS{1'b0}}}) : root_ff;
      end else if (cmd.acc_h && row_last && (col_ff != '0)) begin
         term = itv_pkg::TERM_W'({hx_ff, {itv_pkg::FRAC_BITS{1'b0}}});
      end
   end

   assign sum_ext = {1'b0, sum_ff} + (itv_pkg::SUM_W + 1)'(term);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      sum_in  = sum_ff;
      clip_in = clip_ff;
      left_in = left_ff;
      priority if (frame_clear) begin
         col_in  = '0;
         row_in  = '0;
         sum_in  = '0;
         clip_in = 1'b0;
         left_in = '0;
      end else if (cmd.acc_v || cmd.acc_h) begin
         if (sum_ext[itv_pkg::SUM_W]) begin
            sum_in  = itv_pkg::SUM_MAX;
            clip_in = 1'b1;
         end else begin
            sum_in = sum_ext[itv_pkg::SUM_W-1:0];
         end
      end else if (cmd.commit) begin
         left_in = pix_ff;
         if (!col_last) begin
            col_in = col_ff + itv_pkg::COL_W'(1);
         end else if (!row_last) begin
            col_in = '0;
            row_in = row_ff + itv_pkg::ROW_W'(1);
         end else begin
            col_in  = '0;
            row_in  = '0;
            sum_in  = '0;
            clip_in = 1'b0;
            left_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         sum_ff  <= '0;
         clip_ff <= 1'b0;
         left_ff <= '0;
         step_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         sum_ff  <= sum_in;
         clip_ff <= clip_in;
         left_ff <= left_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_pixel) pix_ff <= req_pixel;
      if (cmd.cap_up) up_ff <= rd_data;
      if (cmd.cap_diff) begin
         dx_ff <= itv_pkg::abs_diff(up_ff, rd_data);
         dy_ff <= itv_pkg::abs_diff(up_ff, pix_ff);
         hx_ff <= itv_pkg::abs_diff(left_ff, pix_ff);
      end
      if (cmd.sq_x) sq_ff <= mul_prod;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (cmd.load_out) begin
         out_sum_ff <= sum_ff;
         out_sat_ff <= clip_ff;
      end
   end

   assign rsp_total_variation = out_sum_ff;
   assign rsp_saturated       = out_sat_ff;

   `ITV_ASSERT_SAME(a_clip_pins_sum, clock, reset, clip_ff, sum_ff == itv_pkg::SUM_MAX,
      "clip flag set below the sum ceiling")
   `ITV_ASSERT_SAME(a_col_in_row, clock, reset, 1'b1, itv_pkg::SIZE_W'(col_ff) < w_eff,
      "column count past the row width")

endmodule

// File: hdl/isotropic_total_variation_top.sv
// ----------------------------------------------------------------------------
// isotropic_total_variation_top
// isotropic total variation of a raster frame, one sum per frame
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// req      in         req_valid / req_stall     req_pixel
// rsp      out        rsp_valid / rsp_stall     rsp_total_variation, rsp_saturated
// csr      in/out     psel penable pwrite pready paddr pwdata prdata
//
// a pixel with a root term squares dx and dy and then runs the root iteration,
// two radicand bits per step; a pixel without one skips both
// the line buffer is one RAM port pair, read twice per pixel
// reset is synchronous, clears the position and the sum, and sets both sizes
// to their maximum
// a stalled result is held in the output word while the next pixel is taken
// ----------------------------------------------------------------------------
module isotropic_total_variation_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [itv_pkg::PIXEL_BITS-1:0]   req_pixel,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [itv_pkg::SUM_W-1:0]               rsp_total_variation,
   output logic                                    rsp_saturated,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [itv_pkg::CSR_ADDR_W-1:0]          paddr,
   input  logic [itv_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [itv_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   logic [itv_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [itv_pkg::SIZE_W-1:0] height_ff, height_in;
   logic                       csr_write;
   logic                       reg_sel;
   itv_pkg::ctrl_cmd_type      cmd;
   itv_pkg::dp_status_type     status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = paddr[2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (reg_sel)
            itv_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[itv_pkg::SIZE_W-1:0];
            itv_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[itv_pkg::SIZE_W-1:0];
            default:                   width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= itv_pkg::WIDTH_MAX;
         height_ff <= itv_pkg::HEIGHT_MAX;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         itv_pkg::REG_IMAGE_WIDTH:  prdata = itv_pkg::CSR_DATA_W'(width_ff);
         itv_pkg::REG_IMAGE_HEIGHT: prdata = itv_pkg::CSR_DATA_W'(height_ff);
         default:                   prdata = '0;
      endcase
   end

   itv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // any register write restarts the frame
   itv_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .image_width        (width_ff),
      .image_height       (height_ff),
      .frame_clear        (csr_write),
      .req_pixel          (req_pixel),
      .cmd                (cmd),
      .status             (status),
      .rsp_total_variation(rsp_total_variation),
      .rsp_saturated      (rsp_saturated)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isotropic total variation testbench
// streams raster frames of signed pixels through the block under random
// idling and back pressure, predicts every frame total and its clip flag,
// and compares each returned word with the oldest predicted one
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 600;
   localparam int SETTLE_CYCLES  = 40;
   localparam int TAIL_CYCLES    = 80;
   localparam int PIXEL_TARGET   = 850;
   localparam int CUT_RUN        = 24;
   localparam int SHOW_LIMIT     = 10;

   typedef longint unsigned u64_type;
   typedef logic signed [itv_pkg::PIXEL_BITS-1:0] pixel_type;
   typedef logic [itv_pkg::SIZE_W-1:0] size_type;

   localparam u64_type SUM_CEILING = u64_type'(itv_pkg::SUM_MAX);

   typedef struct packed {
      logic [itv_pkg::SUM_W-1:0] total;
      logic                      clipped;
   } frame_total_type;

   typedef enum int {NOISE, NEAR_BASE, RAILS, FLAT} pixel_style_type;

   localparam pixel_type RAIL_VALUES [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};

   class tv_ledger;
      pixel_type       line_buf [itv_pkg::MAX_WIDTH];
      pixel_type       prev_pixel;
      int unsigned     col;
      int unsigned     row;
      u64_type         sum;
      bit              clipped;
      size_type        width_reg;
      size_type        height_reg;
      frame_total_type totals_due [$];
      int              failures;

      function new();
         foreach (line_buf[i]) line_buf[i] = '0;
         width_reg  = itv_pkg::WIDTH_MAX;
         height_reg = itv_pkg::HEIGHT_MAX;
         failures   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         prev_pixel = '0;
         col        = 0;
         row        = 0;
         sum        = 0;
         clipped    = 1'b0;
      endfunction

      // zero acts as one, oversize acts as the maximum
      function int unsigned span(size_type v, int unsigned vmax);
         if (v == 0) return 1;
         if (v > vmax) return vmax;
         return v;
      endfunction

      function int unsigned frame_pixels();
         return span(width_reg, itv_pkg::MAX_WIDTH) * span(height_reg, itv_pkg::MAX_HEIGHT);
      endfunction

      function void miss(string msg);
         failures++;
         if (failures <= SHOW_LIMIT) $display("%s", msg);
      endfunction

      function void set_register(logic idx, size_type v);
         if (idx == itv_pkg::REG_IMAGE_WIDTH) width_reg = v;
         else height_reg = v;
         clear_frame();
      endfunction

      function void check_register(logic idx, logic [31:0] got);
         logic [31:0] want;
         want = 32'((idx == itv_pkg::REG_IMAGE_WIDTH) ? width_reg : height_reg);
         if (got !== want)
            miss($sformatf("register %0d read: expected %0d, got %0d", idx, want, got));
      endfunction

      function u64_type gap(pixel_type a, pixel_type b);
         int d;
         d = int'(a) - int'(b);
         return u64_type'((d < 0) ? -d : d);
      endfunction

      // floor of sqrt(s) with 8 fraction bits
      function u64_type root_q8(u64_type s);
         u64_type n;
         u64_type r;
         n = s << 16;
         r = u64_type'($sqrt(real'(n)));
         while (r * r > n) r--;
         while ((r + 1) * (r + 1) <= n) r++;
         return r;
      endfunction

      function void add_term(u64_type term);
         if (term > SUM_CEILING - sum) begin
            sum     = SUM_CEILING;
            clipped = 1'b1;
         end else begin
            sum += term;
         end
      endfunction

      function void take_pixel(pixel_type x);
         int unsigned     w;
         int unsigned     h;
         int unsigned     c;
         int unsigned     r;
         pixel_type       up;
         u64_type         dx;
         u64_type         dy;
         frame_total_type done;
         w = span(width_reg, itv_pkg::MAX_WIDTH);
         h = span(height_reg, itv_pkg::MAX_HEIGHT);
         c = (col >= w) ? w - 1 : col;
         r = (row >= h) ? h - 1 : row;
         if (r > 0) begin
            up = line_buf[c];
            dy = gap(up, x);
            if (c + 1 < w) begin
               dx = gap(up, line_buf[c + 1]);
               add_term(root_q8(dx * dx + dy * dy));
            end else begin
               add_term(dy << 8);
            end
         end
         if (r == h - 1 && c > 0) add_term(gap(prev_pixel, x) << 8);
         line_buf[c] = x;
         prev_pixel  = x;
         if (c + 1 >= w) begin
            if (r + 1 >= h) begin
               done.total   = sum[itv_pkg::SUM_W-1:0];
               done.clipped = clipped;
               totals_due.push_back(done);
               clear_frame();
            end else begin
               col = 0;
               row = r + 1;
            end
         end else begin
            col = c + 1;
            row = r;
         end
      endfunction

      function void check_total(logic [itv_pkg::SUM_W-1:0] tv, logic sat);
         frame_total_type want;
         if (totals_due.size() == 0) begin
            miss($sformatf("frame total %0d (saturated %0b) with none pending", tv, sat));
            return;
         end
         want = totals_due.pop_front();
         if (tv !== want.total)
            miss($sformatf("total_variation: expected %0d, got %0d", want.total, tv));
         if (sat !== want.clipped)
            miss($sformatf("saturated: expected %0b, got %0b", want.clipped, sat));
      endfunction

      function void close_out();
         if (totals_due.size() != 0)
            miss($sformatf("%0d frame totals never arrived", totals_due.size()));
      endfunction
   endclass

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   pixel_type                         req_pixel = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [itv_pkg::SUM_W-1:0]         rsp_total_variation;
   logic                              rsp_saturated;
   logic                              psel      = 1'b0;
   logic                              penable   = 1'b0;
   logic                              pwrite    = 1'b0;
   logic [itv_pkg::CSR_ADDR_W-1:0]    paddr     = '0;
   logic [itv_pkg::CSR_DATA_W-1:0]    pwdata    = '0;
   logic [itv_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;

   bit        sender_idles   = 1'b1;
   bit        receiver_idles = 1'b1;
   bit        long_hold      = 1'b0;
   int        hold_cycles    = 0;
   int        idle_cycles    = 0;
   int        pixels_sent    = 0;
   pixel_type frame_base     = '0;
   tv_ledger  ledger         = new();

   isotropic_total_variation_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_total_variation (rsp_total_variation),
      .rsp_saturated       (rsp_saturated),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) ledger.check_total(rsp_total_variation, rsp_saturated);
         if (req_valid && !req_stall) ledger.take_pixel(req_pixel);
      end
   end

   // receiver: one long hold when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold && hold_cycles < LONG_HOLD) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < 21);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pixel(pixel_type x);
      while (sender_idles && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.totals_due.size() != 0);
   endtask

   task automatic csr_write(logic idx, size_type v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {21'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      ledger.set_register(idx, v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(logic idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      ledger.check_register(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // sizes change only once the block has gone quiet
   task automatic set_size(size_type w, size_type h);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(itv_pkg::REG_IMAGE_WIDTH, w);
      csr_write(itv_pkg::REG_IMAGE_HEIGHT, h);
      csr_read_check(itv_pkg::REG_IMAGE_WIDTH);
      csr_read_check(itv_pkg::REG_IMAGE_HEIGHT);
   endtask

   function automatic pixel_type pick_pixel(pixel_style_type style);
      case (style)
         NOISE:     return pixel_type'($urandom);
         NEAR_BASE: return frame_base + pixel_type'($urandom_range(16)) - pixel_type'(8);
         RAILS:     return RAIL_VALUES[$urandom_range(3)];
         default:   return frame_base;
      endcase
   endfunction

   task automatic send_frames(int frames);
      int unsigned     count;
      int unsigned     roll;
      pixel_style_type style;
      count = ledger.frame_pixels();
      repeat (frames) begin
         frame_base = pixel_type'($urandom);
         roll = $urandom_range(99);
         style = (roll < 40) ? NOISE : (roll < 70) ? NEAR_BASE : (roll < 85) ? RAILS : FLAT;
         repeat (count) send_pixel(pick_pixel(style));
      end
   endtask

   initial begin
      pixel_type   extreme_frame [9];
      pixel_type   rail_run [4];
      int          phase;
      size_type    w;
      size_type    h;
      extreme_frame = '{16'sh7fff, 16'sh8000, 16'sh7fff,
                        16'sh8000, 16'sh7fff, 16'sh8000,
                        16'sh0000, 16'shffff, 16'sh7fff};
      rail_run = '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shfffe};
      phase = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check(itv_pkg::REG_IMAGE_WIDTH);
      csr_read_check(itv_pkg::REG_IMAGE_HEIGHT);

      // interior, last row, last column and corner all in one small frame
      set_size(11'd3, 11'd3);
      foreach (extreme_frame[i]) send_pixel(extreme_frame[i]);
      // single pixel frames, then zero sizes acting as one
      set_size(11'd1, 11'd1);
      send_pixel(16'sh8000);
      send_pixel(16'sh7fff);
      set_size(11'd0, 11'd0);
      send_pixel(16'sh0000);
      send_pixel(16'shffff);
      // one row only, one column only
      set_size(11'd4, 11'd1);
      foreach (rail_run[i]) send_pixel(rail_run[i]);
      set_size(11'd1, 11'd4);
      foreach (rail_run[i]) send_pixel(rail_run[i]);
      // oversize values read back raw; the short run is cut off by the next write
      set_size(11'd2047, 11'd1500);
      repeat (CUT_RUN) send_pixel(pixel_type'($urandom));

      while ((pixels_sent < PIXEL_TARGET) || (phase < 6)) begin
         phase++;
         w = ($urandom_range(99) < 80) ? size_type'($urandom_range(1, 8))
                                       : size_type'($urandom_range(9, 48));
         h = size_type'($urandom_range(1, 6));
         if (phase == 3) begin
            // stretch with no idling on either side
            set_size(w, h);
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
            send_frames(6);
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
         end else if (phase == 6) begin
            // tiny frames against a stalled receiver fill the block
            set_size(11'd2, 11'd2);
            long_hold = 1'b1;
            send_frames(20);
         end else begin
            set_size(w, h);
            send_frames($urandom_range(1, 3));
            if ($urandom_range(3) == 0) drain();
            send_frames($urandom_range(1, 3));
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      ledger.close_out();
      if (ledger.failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/itv_pkg.sv
hdl/itv_ram.sv
hdl/itv_ctrl.sv
hdl/itv_dp.sv
hdl/isotropic_total_variation_top.sv
test/testbench.sv
